[rtl/core/master_eq_limiter_stage_unit_macros.svh]
// Assertion macros shared by the master EQ / limiter stage RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef MASTER_EQ_LIMITER_STAGE_UNIT_MACROS_SVH
`define MASTER_EQ_LIMITER_STAGE_UNIT_MACROS_SVH

// Invariant that holds at every clock edge out of reset.
`define EQLIM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Trigger in one cycle, consequence in the next.
`define EQLIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/eqlim_pkg.sv]
// Shared constants, codes and types of the master EQ / limiter stage.
// No dependencies.
`timescale 1ns / 1ps
package eqlim_pkg;

  localparam int MIX_BITS_DEF = 24;

  localparam int VOL_W    = 7;
  localparam int GAIN_W   = 15;
  localparam int MG_W     = 16;  // master q15 gain, up to unity
  localparam int LG_W     = 16;  // limiter q15 gain, up to unity
  localparam int SMP_W    = 16;
  localparam int PEAK_W   = 24;
  localparam int IDX_W    = 3;
  localparam int CFG_DW   = 15;
  localparam int IN_DW    = 64;
  localparam int OUT_DW   = 56;

  localparam int VOL_MAX   = 100;
  localparam int GAIN_MIN  = 256;
  localparam int GAIN_MAX  = 16384;
  localparam int UNITY_Q12 = 4096;
  localparam int UNITY_Q15 = 32768;
  localparam int ALPHA_LO  = 1058;
  localparam int ALPHA_HI  = 13327;
  // vol * 32768 / 100 == (vol * VOL_RECIP) >> VOL_SHIFT for vol in 0..100
  localparam int VOL_RECIP = 1342178;
  localparam int VOL_SHIFT = 12;
  localparam int RECIP_W   = 21;
  // limit << 15 / |full-scale negative| for any mix width of 17 bits or more
  localparam int LIM_NEED  = 32767;
  localparam int REC_SHIFT = 9;

  // register indexes
  localparam logic [IDX_W-1:0] REG_VOLUME = 3'd0;
  localparam logic [IDX_W-1:0] REG_MUTE   = 3'd1;
  localparam logic [IDX_W-1:0] REG_BASS   = 3'd2;
  localparam logic [IDX_W-1:0] REG_MID    = 3'd3;
  localparam logic [IDX_W-1:0] REG_TREBLE = 3'd4;
  localparam logic [IDX_W-1:0] REG_LIMEN  = 3'd5;

  // multiply steps of one channel
  localparam logic [2:0] OP_MST = 3'd0;
  localparam logic [2:0] OP_LO  = 3'd1;
  localparam logic [2:0] OP_HI  = 3'd2;
  localparam logic [2:0] OP_BAS = 3'd3;
  localparam logic [2:0] OP_MID = 3'd4;
  localparam logic [2:0] OP_TRB = 3'd5;
  localparam logic [2:0] OP_LIM = 3'd6;

  typedef struct packed {
    logic [MG_W-1:0]   master;
    logic [GAIN_W-1:0] bass;
    logic [GAIN_W-1:0] mid;
    logic [GAIN_W-1:0] treble;
    logic              lim_en;
    logic              eq_on;
  } cfg_t;

endpackage

[rtl/core/master_eq_limiter_stage_unit.sv]
// Top level of the master gain, three-band EQ and peak limiter stage.
// Depends on eqlim_pkg, eqlim_cfg, eqlim_mul and the assertion macro header.
`timescale 1ns / 1ps
//
// channel | dir | handshake          | word
// --------+-----+--------------------+---------------------------------------
// in_     | in  | tvalid/tready      | tdata: left_mix, right_mix; tlast
// out_    | out | tvalid/tready      | tdata: left_out, right_out, peak; tlast
// cfg_    | in  | valid/ready        | index, data (register write)
//
// Each frame runs from the accepting cycle through, per channel, an issue and a write-back
// state for each multiply on the shared multiplier (gain, 5 EQ steps when the EQ is active,
// limiter when enabled) and a state to close the channel, then a state to hand the word
// over; only after that handover is the next frame accepted.
// Reset (rst_n low, synchronous) clears filters, peak and output valid; gain is unity.
// The sequencer waits at the end of a frame only while the output register is full.
`include "master_eq_limiter_stage_unit_macros.svh"
module master_eq_limiter_stage_unit import eqlim_pkg::*; #(
  parameter int MIX_BITS = MIX_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // left_mix[31:0], right_mix[63:32]
  input  logic              in_tlast,   // period_end
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // left_out[15:0], right_out[31:16], peak[55:32]
  output logic              out_tlast,  // period_done
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int N     = MIX_BITS;
  localparam int A_W   = (MIX_BITS + 1 > 32) ? MIX_BITS + 1 : 32;
  localparam int B_W   = LG_W + 2;
  localparam int P_W   = A_W + B_W;
  localparam int ACC_W = P_W + 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_WB   = 3'd2;
  localparam logic [2:0] ST_CH   = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam logic signed [N-1:0] MIX_MAX_V = {1'b0, {(N-1){1'b1}}};
  localparam logic signed [N-1:0] MIX_MIN_V = {1'b1, {(N-1){1'b0}}};
  localparam logic signed [N-1:0] S16_MAX   = N'(32767);
  localparam logic signed [N-1:0] S16_MIN   = N'(-32768);

  cfg_t cfg;

  logic [2:0]            st_r;
  logic [2:0]            op_r;
  logic                  ch_r;
  logic signed [31:0]    xl_r, xr_r;
  logic                  last_r;
  logic signed [N-1:0]   v_r;
  logic signed [N-1:0]   lo_r [2];
  logic signed [N-1:0]   hi_r [2];
  logic signed [ACC_W-1:0] acc_r;
  logic [LG_W-1:0]       gain_r;
  logic [N-1:0]          peak_r;
  logic [SMP_W-1:0]      res_l_r, res_r_r;
  logic [SMP_W-1:0]      out_l_r, out_r_r;
  logic [PEAK_W-1:0]     out_pk_r;
  logic                  out_last_r, out_vld_r;

  logic signed [A_W-1:0] mul_a, v_e, lo_e, hi_e;
  logic signed [B_W-1:0] mul_b;
  logic signed [P_W-1:0] prod;
  logic signed [P_W-1:0] sh15;
  logic signed [ACC_W-1:0] acc_sum;
  logic [LG_W-1:0]       gain_upd;
  logic                  mul_en;
  logic [N:0]            mag;
  logic [SMP_W-1:0]      sat16;
  logic [A_W-1:0]        pk_e;
  logic                  out_load;

  function automatic logic signed [N-1:0] clamp_mix(input logic signed [ACC_W-1:0] s);
    if (s > ACC_W'(MIX_MAX_V)) return MIX_MAX_V;
    if (s < ACC_W'(MIX_MIN_V)) return MIX_MIN_V;
    return N'(s);
  endfunction

  eqlim_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // Operands of the shared multiplier, picked by the current step.
  assign v_e  = A_W'(v_r);
  assign lo_e = A_W'(lo_r[ch_r]);
  assign hi_e = A_W'(hi_r[ch_r]);

  // Limiter gain: drop to the limit on a full-scale negative sample, else recover.
  always_comb begin
    if (v_r == MIX_MIN_V) begin
      gain_upd = (gain_r > LG_W'(LIM_NEED)) ? LG_W'(LIM_NEED) : gain_r;
    end else if (gain_r < LG_W'(UNITY_Q15)) begin
      gain_upd = gain_r + ((LG_W'(UNITY_Q15) - gain_r) >> REC_SHIFT);
    end else begin
      gain_upd = gain_r;
    end
  end

  always_comb begin
    unique case (op_r)
      OP_MST: begin
        mul_a = A_W'(ch_r ? xr_r : xl_r);
        mul_b = $signed(B_W'(cfg.master));
      end
      OP_LO: begin
        mul_a = v_e - lo_e;
        mul_b = B_W'(ALPHA_LO);
      end
      OP_HI: begin
        mul_a = v_e - hi_e;
        mul_b = B_W'(ALPHA_HI);
      end
      OP_BAS: begin
        mul_a = lo_e;
        mul_b = $signed(B_W'(cfg.bass));
      end
      OP_MID: begin
        mul_a = hi_e - lo_e;
        mul_b = $signed(B_W'(cfg.mid));
      end
      OP_TRB: begin
        mul_a = v_e - hi_e;
        mul_b = $signed(B_W'(cfg.treble));
      end
      OP_LIM: begin
        mul_a = v_e;
        mul_b = $signed(B_W'(gain_upd));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_en = (st_r == ST_MUL);

  eqlim_mul #(.A_W(A_W), .B_W(B_W)) u_mul (
    .clk(clk),
    .en (mul_en),
    .a  (mul_a),
    .b  (mul_b),
    .p_r(prod)
  );

  assign sh15    = prod >>> 15;
  assign acc_sum = acc_r + ACC_W'(prod);

  // Magnitude and 16-bit saturation of the finished channel sample.
  always_comb begin
    mag = v_r[N-1] ? (N+1)'(-(N+1)'(v_r)) : (N+1)'(v_r);
    if (v_r > S16_MAX) sat16 = 16'h7fff;
    else if (v_r < S16_MIN) sat16 = 16'h8000;
    else sat16 = v_r[SMP_W-1:0];
  end

  assign pk_e     = A_W'(peak_r);
  assign out_load = (st_r == ST_FIN) && (!out_vld_r || out_tready);
  assign in_tready = (st_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      op_r      <= OP_MST;
      ch_r      <= 1'b0;
      lo_r[0]   <= '0;
      lo_r[1]   <= '0;
      hi_r[0]   <= '0;
      hi_r[1]   <= '0;
      gain_r    <= LG_W'(UNITY_Q15);
      peak_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (out_load) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;

      unique case (st_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            xl_r   <= $signed(in_tdata[31:0]);
            xr_r   <= $signed(in_tdata[63:32]);
            last_r <= in_tlast;
            ch_r   <= 1'b0;
            op_r   <= OP_MST;
            st_r   <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (op_r == OP_LIM) gain_r <= gain_upd;
          st_r <= ST_WB;
        end
        ST_WB: begin
          // write back the product and pick the next step
          unique case (op_r)
            OP_MST: begin
              v_r <= clamp_mix(ACC_W'(sh15));
              if (cfg.eq_on) begin
                op_r <= OP_LO;
                st_r <= ST_MUL;
              end else if (cfg.lim_en) begin
                op_r <= OP_LIM;
                st_r <= ST_MUL;
              end else begin
                st_r <= ST_CH;
              end
            end
            OP_LO: begin
              lo_r[ch_r] <= lo_r[ch_r] + N'(sh15);
              op_r <= OP_HI;
              st_r <= ST_MUL;
            end
            OP_HI: begin
              hi_r[ch_r] <= hi_r[ch_r] + N'(sh15);
              op_r <= OP_BAS;
              st_r <= ST_MUL;
            end
            OP_BAS: begin
              acc_r <= ACC_W'(prod);
              op_r  <= OP_MID;
              st_r  <= ST_MUL;
            end
            OP_MID: begin
              acc_r <= acc_sum;
              op_r  <= OP_TRB;
              st_r  <= ST_MUL;
            end
            OP_TRB: begin
              v_r <= clamp_mix(acc_sum >>> 12);
              if (cfg.lim_en) begin
                op_r <= OP_LIM;
                st_r <= ST_MUL;
              end else begin
                st_r <= ST_CH;
              end
            end
            default: begin
              v_r  <= N'(sh15);
              st_r <= ST_CH;
            end
          endcase
        end
        ST_CH: begin
          // close the channel: track the peak, hold the saturated sample
          if (mag[N-1:0] > peak_r) peak_r <= mag[N-1:0];
          if (!ch_r) begin
            res_l_r <= sat16;
            ch_r    <= 1'b1;
            op_r    <= OP_MST;
            st_r    <= ST_MUL;
          end else begin
            res_r_r <= sat16;
            st_r    <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            if (last_r) peak_r <= '0;
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // Output register: payload loads with the handoff, no reset needed.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_l_r    <= res_l_r;
      out_r_r    <= res_r_r;
      out_pk_r   <= (pk_e > A_W'(24'hffffff)) ? 24'hffffff : pk_e[PEAK_W-1:0];
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_pk_r, out_r_r, out_l_r};
  assign out_tlast  = out_last_r;

  `EQLIM_ASSERT(a_gain_le_unity, gain_r <= LG_W'(UNITY_Q15), "limiter gain above unity")
  `EQLIM_ASSERT_NEXT(a_start_left, in_tvalid && in_tready, st_r == ST_MUL && op_r == OP_MST && !ch_r, "frame did not start on left gain step")
  `EQLIM_ASSERT_NEXT(a_handoff, out_load, out_vld_r && st_r == ST_IDLE, "result not handed to output register")
  `EQLIM_ASSERT_NEXT(a_peak_clear, out_load && last_r, peak_r == '0, "peak not cleared after period end")

endmodule

[rtl/core/eqlim_cfg.sv]
// Configuration registers of the master EQ / limiter stage.
// Depends on eqlim_pkg.
`timescale 1ns / 1ps
module eqlim_cfg import eqlim_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output cfg_t              cfg
);

  logic [VOL_W-1:0]  vol_r;
  logic              mute_r;
  logic [GAIN_W-1:0] bass_r, mid_r, treb_r;
  logic              lim_en_r;
  logic [VOL_W-1:0]  vol_w;
  logic [GAIN_W-1:0] gain_w;
  logic [VOL_W+RECIP_W-1:0] vol_prod;

  assign cfg_ready = 1'b1;

  // saturate written values into their legal ranges
  always_comb begin
    vol_w = cfg_data[VOL_W-1:0];
    if (vol_w > VOL_W'(VOL_MAX)) vol_w = VOL_W'(VOL_MAX);
    gain_w = cfg_data[GAIN_W-1:0];
    if (gain_w < GAIN_W'(GAIN_MIN)) gain_w = GAIN_W'(GAIN_MIN);
    else if (gain_w > GAIN_W'(GAIN_MAX)) gain_w = GAIN_W'(GAIN_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r    <= VOL_W'(80);
      mute_r   <= 1'b0;
      bass_r   <= GAIN_W'(UNITY_Q12);
      mid_r    <= GAIN_W'(UNITY_Q12);
      treb_r   <= GAIN_W'(UNITY_Q12);
      lim_en_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_VOLUME: vol_r    <= vol_w;
        REG_MUTE:   mute_r   <= cfg_data[0];
        REG_BASS:   bass_r   <= gain_w;
        REG_MID:    mid_r    <= gain_w;
        REG_TREBLE: treb_r   <= gain_w;
        REG_LIMEN:  lim_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign vol_prod = (VOL_W+RECIP_W)'(vol_r) * (VOL_W+RECIP_W)'(VOL_RECIP);

  always_comb begin
    cfg.master = mute_r ? '0 : vol_prod[VOL_SHIFT +: MG_W];
    cfg.bass   = bass_r;
    cfg.mid    = mid_r;
    cfg.treble = treb_r;
    cfg.lim_en = lim_en_r;
    cfg.eq_on  = (bass_r != GAIN_W'(UNITY_Q12)) || (mid_r != GAIN_W'(UNITY_Q12))
                 || (treb_r != GAIN_W'(UNITY_Q12));
  end

endmodule

[rtl/core/eqlim_mul.sv]
// Shared signed multiplier with registered product.
// Depends on eqlim_pkg.
`timescale 1ns / 1ps
module eqlim_mul import eqlim_pkg::*; #(
  parameter int A_W = 33,
  parameter int B_W = 18
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [A_W-1:0]   a,
  input  logic signed [B_W-1:0]   b,
  output logic signed [A_W+B_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    if (en) p_r <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

endmodule

[tb/tb.sv]
// Self-checking bench for master_eq_limiter_stage_unit: directed table, register extremes, then random frames.
// Predicts every output word in place; depends on eqlim_pkg and the DUT only.
`timescale 1ns / 1ps
module tb;
  import eqlim_pkg::*;

  localparam int MIXB = 24;
  localparam longint MIXMAX = (64'sd1 <<< (MIXB - 1)) - 1;
  localparam longint MIXMIN = -MIXMAX - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DW-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  master_eq_limiter_stage_unit #(.MIX_BITS(MIXB)) dut (.*);

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic [23:0] peak;
    logic        done;
  } frame_res_t;

  // predictor copy of registers and state
  longint vol, mute, bass, mid, treb, limen;
  longint lo_f [2];
  longint hi_f [2];
  longint lim_gain;
  longint peak_run;

  frame_res_t pending_frames[$];
  int errors = 0;
  bit busy_long = 1'b0;

  function automatic longint clampmix(longint v);
    if (v > MIXMAX) return MIXMAX;
    if (v < MIXMIN) return MIXMIN;
    return v;
  endfunction

  function automatic longint clampgain(longint g);
    g = g & 16'h7FFF;
    if (g < GAIN_MIN) g = GAIN_MIN;
    if (g > GAIN_MAX) g = GAIN_MAX;
    return g;
  endfunction

  task automatic predict_reset();
    vol = 80; mute = 0; bass = UNITY_Q12; mid = UNITY_Q12; treb = UNITY_Q12; limen = 1;
    lo_f[0] = 0; lo_f[1] = 0; hi_f[0] = 0; hi_f[1] = 0;
    lim_gain = UNITY_Q15; peak_run = 0;
  endtask

  function automatic longint eq_channel(int ch, longint x, longint mg, bit eq_on);
    longint v, m, need, lo, hi;
    v = clampmix((x * mg) >>> 15);
    if (eq_on) begin
      lo = lo_f[ch]; hi = hi_f[ch];
      lo += ((v - lo) * ALPHA_LO) >>> 15;
      hi += ((v - hi) * ALPHA_HI) >>> 15;
      lo_f[ch] = lo; hi_f[ch] = hi;
      v = clampmix((lo * bass + (hi - lo) * mid + (v - hi) * treb) >>> 12);
    end
    if (limen != 0) begin
      m = v < 0 ? -v : v;
      if (m > MIXMAX) begin
        need = (MIXMAX * UNITY_Q15) / m;
        if (need < lim_gain) lim_gain = need;
      end else if (lim_gain < UNITY_Q15) begin
        lim_gain += (UNITY_Q15 - lim_gain) >>> 9;
        if (lim_gain > UNITY_Q15) lim_gain = UNITY_Q15;
      end
      v = (v * lim_gain) >>> 15;
    end
    m = v < 0 ? -v : v;
    if (m > peak_run) peak_run = m;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic frame_res_t predict_frame(logic [31:0] l, logic [31:0] r, logic last);
    frame_res_t f;
    longint mg;
    bit eq_on;
    mg = mute != 0 ? 0 : (vol * UNITY_Q15) / 100;
    eq_on = bass != UNITY_Q12 || mid != UNITY_Q12 || treb != UNITY_Q12;
    f.left = 16'(eq_channel(0, longint'(signed'(l)), mg, eq_on));
    f.right = 16'(eq_channel(1, longint'(signed'(r)), mg, eq_on));
    f.peak = peak_run > 64'hFFFFFF ? 24'hFFFFFF : 24'(peak_run);
    f.done = last;
    if (last) peak_run = 0;
    return f;
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, longint val);
    cfg_index <= idx;
    cfg_data <= CFG_DW'(val);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_VOLUME: begin vol = val & 8'h7F; if (vol > VOL_MAX) vol = VOL_MAX; end
      REG_MUTE: mute = val & 1;
      REG_BASS: bass = clampgain(val);
      REG_MID: mid = clampgain(val);
      REG_TREBLE: treb = clampgain(val);
      REG_LIMEN: limen = val & 1;
      default: ;
    endcase
  endtask

  // drain all pending words plus a margin before touching registers
  task automatic wait_idle();
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (busy_long) return 0;
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_frame(logic [31:0] l, logic [31:0] r, logic last);
    repeat (gap_len()) @(posedge clk);
    in_tdata <= {r, l};
    in_tlast <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 1'b0;
    pending_frames.push_back(predict_frame(l, r, last));
    // the block is busy after a frame is taken, until its word is handed over
    @(posedge clk);
  endtask

  // output side: random stalls, compare each word with the oldest expectation
  always @(posedge clk) begin
    frame_res_t got, exp_f;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[15:0], out_tdata[31:16], out_tdata[55:32], out_tlast};
        if (pending_frames.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          errors++;
        end else begin
          exp_f = pending_frames.pop_front();
          if (got !== exp_f) begin
            $display("%0t: expected l=%h r=%h pk=%h last=%b got l=%h r=%h pk=%h last=%b",
                     $time, exp_f.left, exp_f.right, exp_f.peak, exp_f.done,
                     got.left, got.right, got.peak, got.done);
            errors++;
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) < 70) || busy_long;
    end
  end

  typedef struct {
    logic [31:0] l;
    logic [31:0] r;
    logic        last;
    bit          known;
    frame_res_t  res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic dir_row_t row(logic [31:0] l, logic [31:0] r, logic last);
    dir_row_t d;
    d.l = l; d.r = r; d.last = last; d.known = 1'b0; d.res = '0;
    return d;
  endfunction

  function automatic logic [31:0] rand_mix();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 * 40000)) - 40000);
      2: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      3: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom())};
      default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  initial begin
    frame_res_t f;
    dir_row_t d;
    int phase;
    predict_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero result after reset, full-scale extremes, limiter, period ends
    d = row(32'd0, 32'd0, 1'b1); d.known = 1; d.res = '{16'd0, 16'd0, 24'd0, 1'b1};
    dir_rows.push_back(d);
    dir_rows.push_back(row(32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    dir_rows.push_back(row(32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    dir_rows.push_back(row(32'hFFFF_FFFF, 32'h0000_0001, 1'b0));
    dir_rows.push_back(row(32'h0000_8000, 32'hFFFF_8000, 1'b1));
    dir_rows.push_back(row(32'h00A0_0000, 32'hFF60_0000, 1'b0));
    dir_rows.push_back(row(32'h5555_5555, 32'hAAAA_AAAA, 1'b0));
    dir_rows.push_back(row(32'd100, 32'd200, 1'b1));
    foreach (dir_rows[i]) begin
      if (dir_rows[i].known) begin
        f = predict_frame(dir_rows[i].l, dir_rows[i].r, dir_rows[i].last);
        if (f !== dir_rows[i].res) begin
          $display("%0t: expected %h got %h (table row %0d)", $time, dir_rows[i].res, f, i);
          errors++;
        end
        // undo predictor step: recompute via send_frame on fresh reset-state copy
        predict_reset();
      end
      send_frame(dir_rows[i].l, dir_rows[i].r, dir_rows[i].last);
    end
    wait_idle();

    // register extremes: mute, volume over range, gains clamped, limiter off, then on again
    write_reg(REG_MUTE, 1);
    send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    wait_idle();
    write_reg(REG_MUTE, 0);
    write_reg(REG_VOLUME, 127);
    write_reg(REG_BASS, 16'h7FFF);
    write_reg(REG_MID, 0);
    write_reg(REG_TREBLE, 16384);
    write_reg(REG_LIMEN, 0);
    send_frame(32'h00FF_FFFF, 32'hFF00_0000, 1'b0);
    send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    wait_idle();
    write_reg(REG_LIMEN, 1);
    send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_frame(32'd1000, 32'hFFFF_FC18, 1'b1);
    wait_idle();

    // random phases, each with a new register setting
    for (phase = 0; phase < 9; phase++) begin
      write_reg(REG_VOLUME, phase == 0 ? 0 : phase == 1 ? 100 : $urandom_range(0, 127));
      write_reg(REG_MUTE, phase == 4);
      write_reg(REG_BASS, phase < 2 ? UNITY_Q12 : phase == 2 ? 256 : $urandom_range(0, 32767));
      write_reg(REG_MID, phase < 2 ? UNITY_Q12 : phase == 2 ? 16384 : $urandom_range(0, 32767));
      write_reg(REG_TREBLE, phase < 2 ? UNITY_Q12 : $urandom_range(0, 32767));
      write_reg(REG_LIMEN, phase != 3);
      write_reg(3'd7, $urandom_range(0, 32767));
      busy_long = (phase == 5);
      repeat (150)
        send_frame(rand_mix(), rand_mix(), $urandom_range(0, 15) == 0);
      busy_long = 1'b0;
      wait_idle();
    end
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_frames.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/eqlim_pkg.sv
rtl/core/eqlim_cfg.sv
rtl/core/eqlim_mul.sv
rtl/core/master_eq_limiter_stage_unit.sv
tb/tb.sv
